// ----- rtl/core/bcml_pkg.sv -----
// package for the block-compressed mip chain layout unit
// holds field widths, status and format codes, and per-format byte shifts
// no dependencies
package bcml_pkg;

    localparam int DimW    = 15;
    localparam int BlkW    = 13;
    localparam int CountW  = 5;
    localparam int FmtW    = 3;
    localparam int PackW   = 29;
    localparam int UnpackW = 32;
    localparam int LevelW  = 4;
    localparam int StatW   = 2;
    localparam int ProdW   = 2 * DimW;

    localparam int DefMaxLevels    = 16;
    localparam int DefMaxDimension = 16384;

    localparam logic [StatW-1:0] ST_OK      = 2'd0;
    localparam logic [StatW-1:0] ST_BAD_ARG = 2'd1;
    localparam logic [StatW-1:0] ST_NO_FMT  = 2'd2;

    localparam logic [FmtW-1:0] FMT_BC1  = 3'd0;
    localparam logic [FmtW-1:0] FMT_BC2  = 3'd1;
    localparam logic [FmtW-1:0] FMT_BC3  = 3'd2;
    localparam logic [FmtW-1:0] FMT_BC4  = 3'd3;
    localparam logic [FmtW-1:0] FMT_BC5  = 3'd4;
    localparam logic [FmtW-1:0] FMT_BC6H = 3'd5;
    localparam logic [FmtW-1:0] FMT_BC7  = 3'd6;
    localparam logic [FmtW-1:0] FMT_NONE = 3'd7;

    typedef struct packed {
        logic [DimW-1:0] op_a;
        logic [DimW-1:0] op_b;
    } mul_req_t;

    // log2 of compressed bytes per 4x4 block for BC1 and BC4; 0 for all other formats
    function automatic logic [1:0] block_shift(input logic [FmtW-1:0] fmt);
        logic [1:0] sh;
        case (fmt)
            FMT_BC1, FMT_BC4: sh = 2'd3;
            default:          sh = 2'd0;
        endcase
        if (fmt != FMT_BC1 && fmt != FMT_BC4)
            sh = 2'd0;
        return sh;
    endfunction

    // log2 of decoded bytes per pixel
    function automatic logic [1:0] pixel_shift(input logic [FmtW-1:0] fmt);
        logic [1:0] sh;
        case (fmt)
            FMT_BC4:  sh = 2'd0;
            FMT_BC5:  sh = 2'd1;
            FMT_BC6H: sh = 2'd3;
            default:  sh = 2'd2;
        endcase
        return sh;
    endfunction

endpackage

// ----- rtl/core/bc_mip_chain_layout_unit.sv -----
// mip chain layout unit: one request in, one result transaction per level out, or a
// single error result; a request is taken in S_IDLE and checked in S_CHECK, then each
// level takes four steps (block operands, block size, pixel size, emit) on the shared
// multiplier, and emit waits while the output is stalled; an error answer goes from
// S_CHECK straight to emit, and every result is registered before it is shown.
// rst_n asynchronously clears the sequencer and output valid; the unit then idles.
module bc_mip_chain_layout_unit
    import bcml_pkg::*;
#(
    parameter int MAX_LEVELS    = DefMaxLevels,
    parameter int MAX_DIMENSION = DefMaxDimension
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [DimW-1:0]    root_width,
    input  logic [DimW-1:0]    root_height,
    input  logic [CountW-1:0]  mip_count,
    input  logic [FmtW-1:0]    texture_format,
    output logic               res_valid,
    input  logic               res_stall,
    output logic [DimW-1:0]    level_width,
    output logic [DimW-1:0]    level_height,
    output logic [BlkW-1:0]    blocks_across,
    output logic [BlkW-1:0]    blocks_down,
    output logic [PackW-1:0]   packed_offset,
    output logic [UnpackW-1:0] unpacked_offset,
    output logic [PackW-1:0]   packed_size,
    output logic [UnpackW-1:0] unpacked_size,
    output logic [LevelW-1:0]  level_number,
    output logic [StatW-1:0]   status,
    output logic               last_level
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_MUL_B = 3'd2;
    localparam logic [2:0] S_MUL_P = 3'd3;
    localparam logic [2:0] S_MUL_U = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    localparam logic [DimW+1:0]  MaxDim = (DimW+2)'(MAX_DIMENSION);
    localparam logic [CountW:0]  MaxLev = (CountW+1)'(MAX_LEVELS);

    logic [2:0]          state_reg, state_next;
    logic [DimW-1:0]     cur_w_reg, cur_w_next;
    logic [DimW-1:0]     cur_h_reg, cur_h_next;
    logic [CountW-1:0]   count_reg, count_next;
    logic [FmtW-1:0]     fmt_reg, fmt_next;
    logic [CountW-1:0]   level_reg, level_next;
    logic [PackW-1:0]    pcur_reg, pcur_next;
    logic [UnpackW-1:0]  ucur_reg, ucur_next;
    logic [PackW-1:0]    psize_reg, psize_next;
    logic [UnpackW-1:0]  usize_reg, usize_next;
    logic [StatW-1:0]    err_reg, err_next;

    logic                out_valid_reg, out_valid_next;
    logic [DimW-1:0]     o_w_reg, o_w_next;
    logic [DimW-1:0]     o_h_reg, o_h_next;
    logic [BlkW-1:0]     o_bx_reg, o_bx_next;
    logic [BlkW-1:0]     o_by_reg, o_by_next;
    logic [PackW-1:0]    o_poff_reg, o_poff_next;
    logic [UnpackW-1:0]  o_uoff_reg, o_uoff_next;
    logic [PackW-1:0]    o_psize_reg, o_psize_next;
    logic [UnpackW-1:0]  o_usize_reg, o_usize_next;
    logic [LevelW-1:0]   o_lvl_reg, o_lvl_next;
    logic [StatW-1:0]    o_stat_reg, o_stat_next;
    logic                o_last_reg, o_last_next;

    mul_req_t            mul_req;
    logic [ProdW-1:0]    product;
    logic [DimW:0]       w_plus, h_plus;
    logic [DimW-2:0]     bx, by;
    logic [ProdW+3:0]    shifted;
    logic [1:0]          sh_amt;
    logic                slot_free;
    logic                is_last;
    logic                bad_arg;

    bcml_mul_unit u_mul (
        .clk     (clk),
        .req     (mul_req),
        .product (product)
    );

    assign w_plus    = (DimW+1)'(cur_w_reg) + (DimW+1)'(3);
    assign h_plus    = (DimW+1)'(cur_h_reg) + (DimW+1)'(3);
    assign bx        = w_plus[DimW:2];
    assign by        = h_plus[DimW:2];
    assign slot_free = !out_valid_reg || !res_stall;
    assign is_last   = ((CountW+1)'(level_reg) + (CountW+1)'(1)) == (CountW+1)'(count_reg);
    assign bad_arg   = (cur_w_reg == '0) || (cur_h_reg == '0) || (count_reg == '0)
                       || ((CountW+1)'(count_reg) > MaxLev)
                       || ((DimW+2)'(cur_w_reg) > MaxDim)
                       || ((DimW+2)'(cur_h_reg) > MaxDim);

    always_comb
    begin
        mul_req.op_a = {1'b0, bx};
        mul_req.op_b = {1'b0, by};
        if (state_reg == S_MUL_P)
        begin
            mul_req.op_a = cur_w_reg;
            mul_req.op_b = cur_h_reg;
        end
    end

    // block bytes are 8 or 16, pixel bytes 1, 2, 4 or 8
    assign sh_amt  = (state_reg == S_MUL_P)
                     ? (((fmt_reg == FMT_BC1) || (fmt_reg == FMT_BC4)) ? 2'd3 : 2'd0)
                     : pixel_shift(fmt_reg);
    assign shifted = (state_reg == S_MUL_P && sh_amt == 2'd0)
                     ? ((ProdW+4)'(product) << 4)
                     : ((ProdW+4)'(product) << sh_amt);

    always_comb
    begin
        state_next     = state_reg;
        cur_w_next     = cur_w_reg;
        cur_h_next     = cur_h_reg;
        count_next     = count_reg;
        fmt_next       = fmt_reg;
        level_next     = level_reg;
        pcur_next      = pcur_reg;
        ucur_next      = ucur_reg;
        psize_next     = psize_reg;
        usize_next     = usize_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg && res_stall;
        o_w_next       = o_w_reg;
        o_h_next       = o_h_reg;
        o_bx_next      = o_bx_reg;
        o_by_next      = o_by_reg;
        o_poff_next    = o_poff_reg;
        o_uoff_next    = o_uoff_reg;
        o_psize_next   = o_psize_reg;
        o_usize_next   = o_usize_reg;
        o_lvl_next     = o_lvl_reg;
        o_stat_next    = o_stat_reg;
        o_last_next    = o_last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cur_w_next = root_width;
                    cur_h_next = root_height;
                    count_next = mip_count;
                    fmt_next   = texture_format;
                    level_next = '0;
                    pcur_next  = '0;
                    ucur_next  = '0;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (bad_arg)
                begin
                    err_next   = ST_BAD_ARG;
                    state_next = S_EMIT;
                end
                else if (fmt_reg == FMT_NONE)
                begin
                    err_next   = ST_NO_FMT;
                    state_next = S_EMIT;
                end
                else
                begin
                    err_next   = ST_OK;
                    state_next = S_MUL_B;
                end
            end
            S_MUL_B:
            begin
                state_next = S_MUL_P;
            end
            S_MUL_P:
            begin
                psize_next = shifted[PackW-1:0];
                state_next = S_MUL_U;
            end
            S_MUL_U:
            begin
                usize_next = shifted[UnpackW-1:0];
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    if (err_reg != ST_OK)
                    begin
                        o_w_next     = '0;
                        o_h_next     = '0;
                        o_bx_next    = '0;
                        o_by_next    = '0;
                        o_poff_next  = '0;
                        o_uoff_next  = '0;
                        o_psize_next = '0;
                        o_usize_next = '0;
                        o_lvl_next   = '0;
                        o_stat_next  = err_reg;
                        o_last_next  = 1'b1;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        o_w_next     = cur_w_reg;
                        o_h_next     = cur_h_reg;
                        o_bx_next    = bx[BlkW-1:0];
                        o_by_next    = by[BlkW-1:0];
                        o_poff_next  = pcur_reg;
                        o_uoff_next  = ucur_reg;
                        o_psize_next = psize_reg;
                        o_usize_next = usize_reg;
                        o_lvl_next   = level_reg[LevelW-1:0];
                        o_stat_next  = ST_OK;
                        o_last_next  = is_last;
                        pcur_next    = pcur_reg + psize_reg;
                        ucur_next    = ucur_reg + usize_reg;
                        cur_w_next   = (cur_w_reg > DimW'(1)) ? (cur_w_reg >> 1) : DimW'(1);
                        cur_h_next   = (cur_h_reg > DimW'(1)) ? (cur_h_reg >> 1) : DimW'(1);
                        level_next   = level_reg + CountW'(1);
                        state_next   = is_last ? S_IDLE : S_MUL_B;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            level_reg     <= '0;
            err_reg       <= ST_OK;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            level_reg     <= level_next;
            err_reg       <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_w_reg   <= cur_w_next;
        cur_h_reg   <= cur_h_next;
        count_reg   <= count_next;
        fmt_reg     <= fmt_next;
        pcur_reg    <= pcur_next;
        ucur_reg    <= ucur_next;
        psize_reg   <= psize_next;
        usize_reg   <= usize_next;
        o_w_reg     <= o_w_next;
        o_h_reg     <= o_h_next;
        o_bx_reg    <= o_bx_next;
        o_by_reg    <= o_by_next;
        o_poff_reg  <= o_poff_next;
        o_uoff_reg  <= o_uoff_next;
        o_psize_reg <= o_psize_next;
        o_usize_reg <= o_usize_next;
        o_lvl_reg   <= o_lvl_next;
        o_stat_reg  <= o_stat_next;
        o_last_reg  <= o_last_next;
    end

    assign req_stall       = (state_reg != S_IDLE);
    assign res_valid       = out_valid_reg;
    assign level_width     = o_w_reg;
    assign level_height    = o_h_reg;
    assign blocks_across   = o_bx_reg;
    assign blocks_down     = o_by_reg;
    assign packed_offset   = o_poff_reg;
    assign unpacked_offset = o_uoff_reg;
    assign packed_size     = o_psize_reg;
    assign unpacked_size   = o_usize_reg;
    assign level_number    = o_lvl_reg;
    assign status          = o_stat_reg;
    assign last_level      = o_last_reg;

endmodule

// ----- rtl/core/bcml_mul_unit.sv -----
// shared registered multiplier for the mip chain layout unit
// one 15x15 unsigned product per cycle, result registered and ready in the next cycle
// depends on bcml_pkg
module bcml_mul_unit
    import bcml_pkg::*;
(
    input  logic             clk,
    input  mul_req_t         req,
    output logic [ProdW-1:0] product
);

    logic [ProdW-1:0] product_reg;

    always_ff @(posedge clk)
    begin
        product_reg <= ProdW'(req.op_a) * ProdW'(req.op_b);
    end

    assign product = product_reg;

endmodule
